// ----- rtl/dfsec_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// dfsec_pkg: shared types and constants
// Node and link widths, edge kinds, and the command and status bundles that
// pass between the search controller and its datapath.
// ----------------------------------------------------------------------------
package dfsec_pkg;

   localparam int ID_SPACE = 64;
   localparam int NODE_W   = 6;
   localparam int LINK_W   = 7;
   localparam int CNT_W    = 7;
   localparam int TIME_W   = 8;
   localparam logic [LINK_W-1:0] NULL_LINK = 7'd127;

   typedef enum logic [1:0] {
      KIND_TREE    = 2'd0,
      KIND_BACK    = 2'd1,
      KIND_FORWARD = 2'd2,
      KIND_CROSS   = 2'd3
   } kind_type;

   typedef struct packed {
      logic idle;        // request channel may be taken
      logic accept;      // latch the request payload
      logic ld_read;     // write the edge, read the list tail
      logic ld_commit;   // link the edge into its list
      logic srch_init;   // clear colors, time, stack and root counter
      logic root_next;   // advance to the next root
      logic disc_issue;  // discover a node, read its first edge
      logic disc_root;   // the node discovered is the current root
      logic disc_push;   // push the discovered node
      logic top_edge;    // read the edge under the top cursor
      logic edge_fetch;  // advance cursor, read destination color and time
      logic emit;        // hand the classified edge on
      logic pop;         // finish the top node
      logic pop_load;    // reload the top from the stack memory
      logic flush_out;   // send the held result marked last
      logic finish;      // empty the edge lists
   } cmd_type;

   typedef struct packed {
      logic req_valid;
      logic ld_last;
      logic root_end;
      logic root_vis;
      logic sd_zero;
      logic sd_gt1;
      logic exhausted;
      logic is_tree;
      logic can_emit;
      logic pend_v;
      logic out_free;
   } sts_type;

endpackage
`default_nettype wire

// ----- rtl/dfsec_chan_if.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// dfsec channel interfaces
// Valid/ready channels for edge requests, classified edges and the node
// count register.
// ----------------------------------------------------------------------------
interface dfsec_req_if;
   logic       valid;
   logic       ready;
   logic [5:0] source_node;
   logic [5:0] dest_node;
   logic       last_edge;
   modport source (output valid, source_node, dest_node, last_edge, input ready);
   modport sink (input valid, source_node, dest_node, last_edge, output ready);
endinterface

interface dfsec_rsp_if;
   logic       valid;
   logic       ready;
   logic [5:0] from_node;
   logic [5:0] to_node;
   logic [1:0] edge_kind;
   logic       last_result;
   modport source (output valid, from_node, to_node, edge_kind, last_result, input ready);
   modport sink (input valid, from_node, to_node, edge_kind, last_result, output ready);
endinterface

interface dfsec_csr_if;
   logic       valid;
   logic       ready;
   logic [6:0] node_count;
   modport source (output valid, node_count, input ready);
   modport sink (input valid, node_count, output ready);
endinterface
`default_nettype wire

// ----- rtl/dfsec_ram.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// dfsec_ram: generic single-write, single-read memory
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module dfsec_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic                     re,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic      [WIDTH-1:0]         rdata_ff
);
   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end
endmodule
`default_nettype wire

// ----- rtl/dfsec_ctrl.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// dfsec_ctrl: search sequencer
// Steps through edge loading, root selection, discovery, edge visits and
// pops, issuing one command bundle per cycle to the datapath.
// ----------------------------------------------------------------------------
module dfsec_ctrl (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire dfsec_pkg::sts_type sts,
   output dfsec_pkg::cmd_type      cmd
);
   typedef enum logic [3:0] {
      ST_IDLE, ST_LD1, ST_LD2, ST_SINIT, ST_ROOT, ST_DPUSH,
      ST_TOP, ST_EFETCH, ST_ECLS, ST_POPW, ST_FLUSH
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            cmd.idle = 1'b1;
            if (sts.req_valid) begin
               cmd.accept = 1'b1;
               state_in   = ST_LD1;
            end
         end
         ST_LD1: begin
            cmd.ld_read = 1'b1;
            state_in    = ST_LD2;
         end
         ST_LD2: begin
            cmd.ld_commit = 1'b1;
            state_in      = sts.ld_last ? ST_SINIT : ST_IDLE;
         end
         ST_SINIT: begin
            cmd.srch_init = 1'b1;
            state_in      = ST_ROOT;
         end
         ST_ROOT: begin
            if (sts.root_end) begin
               state_in = ST_FLUSH;
            end else if (sts.root_vis) begin
               cmd.root_next = 1'b1;
            end else begin
               cmd.disc_issue = 1'b1;
               cmd.disc_root  = 1'b1;
               state_in       = ST_DPUSH;
            end
         end
         ST_DPUSH: begin
            cmd.disc_push = 1'b1;
            state_in      = ST_TOP;
         end
         ST_TOP: begin
            if (sts.sd_zero) begin
               state_in = ST_ROOT;
            end else if (sts.exhausted) begin
               cmd.pop  = 1'b1;
               state_in = sts.sd_gt1 ? ST_POPW : ST_TOP;
            end else begin
               cmd.top_edge = 1'b1;
               state_in     = ST_EFETCH;
            end
         end
         ST_EFETCH: begin
            cmd.edge_fetch = 1'b1;
            state_in       = ST_ECLS;
         end
         ST_ECLS: begin
            if (sts.can_emit) begin
               cmd.emit = 1'b1;
               if (sts.is_tree) begin
                  cmd.disc_issue = 1'b1;
                  state_in       = ST_DPUSH;
               end else begin
                  state_in = ST_TOP;
               end
            end
         end
         ST_POPW: begin
            cmd.pop_load = 1'b1;
            state_in     = ST_TOP;
         end
         ST_FLUSH: begin
            if (!sts.pend_v) begin
               cmd.finish = 1'b1;
               state_in   = ST_IDLE;
            end else if (sts.out_free) begin
               cmd.flush_out = 1'b1;
               cmd.finish    = 1'b1;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end
endmodule
`default_nettype wire

// ----- rtl/dfsec_dp.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// dfsec_dp: edge store and search datapath
// Adjacency lists, colors, discovery times, the explicit stack, and the
// result holding and output registers.
// ----------------------------------------------------------------------------
module dfsec_dp #(
   parameter int MAX_NODES = 64,
   parameter int MAX_EDGES = 64
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire dfsec_pkg::cmd_type cmd,
   output dfsec_pkg::sts_type      sts,
   dfsec_req_if.sink               req_ch,
   dfsec_rsp_if.source             rsp_ch,
   dfsec_csr_if.sink               csr_ch
);
   localparam int EW  = $clog2(MAX_EDGES);
   localparam int IDS = dfsec_pkg::ID_SPACE;
   localparam int LIM = (MAX_NODES < IDS) ? MAX_NODES : IDS;
   localparam int SW  = dfsec_pkg::NODE_W + dfsec_pkg::LINK_W + dfsec_pkg::TIME_W;

   logic [dfsec_pkg::CNT_W-1:0]  node_count_ff, used_count;
   logic [dfsec_pkg::CNT_W-1:0]  loaded_ff, r_ff, sd_ff;
   logic [IDS-1:0]               list_v_ff, vis_ff;
   logic [dfsec_pkg::TIME_W-1:0] time_ff, time_inc;
   logic [dfsec_pkg::NODE_W-1:0] ld_s_ff, ld_d_ff, w_ff, disc_n_ff, disc_n;
   logic                         ld_last_ff, ld_ok_ff;
   logic [dfsec_pkg::NODE_W-1:0] cur_u_ff;
   logic [dfsec_pkg::LINK_W-1:0] cur_c_ff, first_c;
   logic [dfsec_pkg::TIME_W-1:0] cur_t_ff;
   logic                         pend_v_ff, out_v_ff, out_last_ff, out_free, can_emit;
   logic [dfsec_pkg::NODE_W-1:0] pend_u_ff, pend_w_ff, out_u_ff, out_w_ff;
   dfsec_pkg::kind_type          pend_k_ff, out_k_ff, kind;

   logic [dfsec_pkg::NODE_W-1:0] to_rd;
   logic [dfsec_pkg::LINK_W-1:0] link_rd, first_rd, tail_rd;
   logic                         blk_rd;
   logic [dfsec_pkg::TIME_W-1:0] dt_rd;
   logic [SW-1:0]                stk_rd;

   logic                         link_we, blk_we, stk_we, stk_re;
   logic [EW-1:0]                link_wa;
   logic [dfsec_pkg::LINK_W-1:0] link_wd;
   logic [dfsec_pkg::NODE_W-1:0] blk_wa;
   logic [dfsec_pkg::CNT_W-1:0]  stk_wa_full, stk_ra_full;

   assign used_count = (node_count_ff > dfsec_pkg::CNT_W'(LIM))
                       ? dfsec_pkg::CNT_W'(LIM) : node_count_ff;
   assign time_inc   = time_ff + 1'b1;
   assign disc_n     = cmd.disc_root ? r_ff[dfsec_pkg::NODE_W-1:0] : w_ff;
   assign first_c    = list_v_ff[disc_n_ff] ? first_rd : dfsec_pkg::NULL_LINK;
   assign out_free   = !out_v_ff || rsp_ch.ready;
   assign can_emit   = !pend_v_ff || out_free;

   always_comb begin
      if (!vis_ff[w_ff]) begin
         kind = dfsec_pkg::KIND_TREE;
      end else if (!blk_rd) begin
         kind = dfsec_pkg::KIND_BACK;
      end else if (cur_t_ff < dt_rd) begin
         kind = dfsec_pkg::KIND_FORWARD;
      end else begin
         kind = dfsec_pkg::KIND_CROSS;
      end
   end

   // Memory port steering.
   assign link_we = ld_ok_ff && (cmd.ld_read || (cmd.ld_commit && list_v_ff[ld_s_ff]));
   assign link_wa = cmd.ld_commit ? tail_rd[EW-1:0] : loaded_ff[EW-1:0];
   assign link_wd = cmd.ld_commit ? loaded_ff : dfsec_pkg::NULL_LINK;
   assign blk_we  = cmd.disc_issue || cmd.pop;
   assign blk_wa  = cmd.pop ? cur_u_ff : disc_n;
   assign stk_we  = cmd.disc_push && (sd_ff != '0) && (sd_ff < dfsec_pkg::CNT_W'(IDS));
   assign stk_re  = cmd.pop && (sd_ff > dfsec_pkg::CNT_W'(1));
   assign stk_wa_full = sd_ff - dfsec_pkg::CNT_W'(1);
   assign stk_ra_full = sd_ff - dfsec_pkg::CNT_W'(2);

   dfsec_ram #(.WIDTH(dfsec_pkg::NODE_W), .DEPTH(MAX_EDGES)) u_to_ram (
      .clock, .we(cmd.ld_read && ld_ok_ff), .waddr(loaded_ff[EW-1:0]), .wdata(ld_d_ff),
      .re(cmd.top_edge), .raddr(cur_c_ff[EW-1:0]), .rdata_ff(to_rd));

   dfsec_ram #(.WIDTH(dfsec_pkg::LINK_W), .DEPTH(MAX_EDGES)) u_link_ram (
      .clock, .we(link_we), .waddr(link_wa), .wdata(link_wd),
      .re(cmd.top_edge), .raddr(cur_c_ff[EW-1:0]), .rdata_ff(link_rd));

   dfsec_ram #(.WIDTH(dfsec_pkg::LINK_W), .DEPTH(IDS)) u_first_ram (
      .clock, .we(cmd.ld_commit && ld_ok_ff && !list_v_ff[ld_s_ff]), .waddr(ld_s_ff),
      .wdata(loaded_ff), .re(cmd.disc_issue), .raddr(disc_n), .rdata_ff(first_rd));

   dfsec_ram #(.WIDTH(dfsec_pkg::LINK_W), .DEPTH(IDS)) u_tail_ram (
      .clock, .we(cmd.ld_commit && ld_ok_ff), .waddr(ld_s_ff), .wdata(loaded_ff),
      .re(cmd.ld_read), .raddr(ld_s_ff), .rdata_ff(tail_rd));

   dfsec_ram #(.WIDTH(1), .DEPTH(IDS)) u_blk_ram (
      .clock, .we(blk_we), .waddr(blk_wa), .wdata(cmd.pop),
      .re(cmd.edge_fetch), .raddr(to_rd), .rdata_ff(blk_rd));

   dfsec_ram #(.WIDTH(dfsec_pkg::TIME_W), .DEPTH(IDS)) u_dt_ram (
      .clock, .we(cmd.disc_issue), .waddr(disc_n), .wdata(time_inc),
      .re(cmd.edge_fetch), .raddr(to_rd), .rdata_ff(dt_rd));

   dfsec_ram #(.WIDTH(SW), .DEPTH(IDS)) u_stack_ram (
      .clock, .we(stk_we), .waddr(stk_wa_full[dfsec_pkg::NODE_W-1:0]),
      .wdata({cur_u_ff, cur_c_ff, cur_t_ff}),
      .re(stk_re), .raddr(stk_ra_full[dfsec_pkg::NODE_W-1:0]), .rdata_ff(stk_rd));

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         node_count_ff <= dfsec_pkg::CNT_W'(IDS);
         loaded_ff     <= '0;
         list_v_ff     <= '0;
         vis_ff        <= '0;
         sd_ff         <= '0;
         r_ff          <= '0;
         time_ff       <= '0;
         pend_v_ff     <= 1'b0;
         out_v_ff      <= 1'b0;
      end else begin
         if (csr_ch.valid) begin
            node_count_ff <= csr_ch.node_count;
         end
         if (cmd.finish) begin
            loaded_ff <= '0;
            list_v_ff <= '0;
         end else if (cmd.ld_commit && ld_ok_ff) begin
            loaded_ff          <= loaded_ff + 1'b1;
            list_v_ff[ld_s_ff] <= 1'b1;
         end
         if (cmd.srch_init) begin
            vis_ff  <= '0;
            sd_ff   <= '0;
            r_ff    <= '0;
            time_ff <= '0;
         end else begin
            if (cmd.root_next) begin
               r_ff <= r_ff + 1'b1;
            end
            if (cmd.disc_issue) begin
               vis_ff[disc_n] <= 1'b1;
               time_ff        <= time_inc;
            end else if (cmd.pop) begin
               time_ff <= time_inc;
            end
            if (cmd.disc_push && (sd_ff < dfsec_pkg::CNT_W'(IDS))) begin
               sd_ff <= sd_ff + 1'b1;
            end else if (cmd.pop) begin
               sd_ff <= sd_ff - 1'b1;
            end
         end
         if (cmd.srch_init || cmd.flush_out) begin
            pend_v_ff <= 1'b0;
         end else if (cmd.emit) begin
            pend_v_ff <= 1'b1;
         end
         if ((cmd.emit && pend_v_ff) || cmd.flush_out) begin
            out_v_ff <= 1'b1;
         end else if (rsp_ch.ready) begin
            out_v_ff <= 1'b0;
         end
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         ld_s_ff    <= req_ch.source_node;
         ld_d_ff    <= req_ch.dest_node;
         ld_last_ff <= req_ch.last_edge;
         ld_ok_ff   <= ({1'b0, req_ch.source_node} < used_count)
                    && ({1'b0, req_ch.dest_node} < used_count)
                    && (loaded_ff < dfsec_pkg::CNT_W'(MAX_EDGES));
      end
      if (cmd.disc_issue) begin
         disc_n_ff <= disc_n;
      end
      if (cmd.disc_push && (sd_ff < dfsec_pkg::CNT_W'(IDS))) begin
         cur_u_ff <= disc_n_ff;
         cur_c_ff <= first_c;
         cur_t_ff <= time_ff;
      end else if (cmd.pop_load) begin
         {cur_u_ff, cur_c_ff, cur_t_ff} <= stk_rd;
      end else if (cmd.edge_fetch) begin
         cur_c_ff <= link_rd;
      end
      if (cmd.edge_fetch) begin
         w_ff <= to_rd;
      end
      if (cmd.emit) begin
         pend_u_ff <= cur_u_ff;
         pend_w_ff <= w_ff;
         pend_k_ff <= kind;
      end
      if ((cmd.emit && pend_v_ff) || cmd.flush_out) begin
         out_u_ff    <= pend_u_ff;
         out_w_ff    <= pend_w_ff;
         out_k_ff    <= pend_k_ff;
         out_last_ff <= cmd.flush_out;
      end
   end

   assign req_ch.ready = cmd.idle;
   assign csr_ch.ready = 1'b1;

   assign rsp_ch.valid       = out_v_ff;
   assign rsp_ch.from_node   = out_u_ff;
   assign rsp_ch.to_node     = out_w_ff;
   assign rsp_ch.edge_kind   = out_k_ff;
   assign rsp_ch.last_result = out_last_ff;

   assign sts.req_valid = req_ch.valid;
   assign sts.ld_last   = ld_last_ff;
   assign sts.root_end  = r_ff >= used_count;
   assign sts.root_vis  = vis_ff[r_ff[dfsec_pkg::NODE_W-1:0]];
   assign sts.sd_zero   = sd_ff == '0;
   assign sts.sd_gt1    = sd_ff > dfsec_pkg::CNT_W'(1);
   assign sts.exhausted = (cur_c_ff >= loaded_ff)
                       || (cur_c_ff >= dfsec_pkg::LINK_W'(MAX_EDGES));
   assign sts.is_tree   = kind == dfsec_pkg::KIND_TREE;
   assign sts.can_emit  = can_emit;
   assign sts.pend_v    = pend_v_ff;
   assign sts.out_free  = out_free;

   // The stack never holds more nodes than the id space.
   a_stack_bound: assert property (@(posedge clock) disable iff (reset)
      sd_ff <= dfsec_pkg::CNT_W'(IDS))
      else $error("stack depth beyond id space");

   // The edge store never holds more than its capacity.
   a_load_bound: assert property (@(posedge clock) disable iff (reset)
      loaded_ff <= dfsec_pkg::CNT_W'(MAX_EDGES))
      else $error("edge count beyond capacity");

   // A classified edge is handed on only when the holding register can move.
   a_emit_room: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> can_emit)
      else $error("edge emitted over a held result");

   // A pop is never issued on an empty stack.
   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      cmd.pop |-> sd_ff != '0)
      else $error("pop on empty stack");

   // After a search the edge lists are empty.
   a_lists_clear: assert property (@(posedge clock) disable iff (reset)
      cmd.finish |=> (loaded_ff == '0) && (list_v_ff == '0))
      else $error("edge lists not cleared after search");
endmodule
`default_nettype wire

// ----- rtl/dfs_edge_classifier_unit.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// dfs_edge_classifier_unit: depth-first search edge classifier
// Loads directed edges into per-node adjacency lists, then runs a
// depth-first search and reports every edge as tree, back, forward or cross.
// ----------------------------------------------------------------------------
//
//   Channel   Direction  Payload                                      Accepted when
//   req_ch    in         source_node, dest_node, last_edge            valid && ready
//   rsp_ch    out        from_node, to_node, edge_kind, last_result   valid && ready
//   csr_ch    in         node_count                                   valid && ready
//
// Each edge request is accepted, then stored while the list tail is read
// from memory, then linked behind that tail.
// The request marked last starts the search. Each edge visit reads the
// cursor, then the destination color and time, then classifies the edge;
// each discovered node is pushed in a step of its own and later popped,
// and a pop that leaves a parent on the stack reloads the stack top from
// memory. An emptied stack returns to root selection, which tests one root
// candidate at a time. The memory reads are registered, hence these steps.
// Reset is synchronous; node_count returns to 64 and the edge lists empty.
// The memories need no clearing pass: per-node valid bits mark live lists
// and visited nodes.
// One classified edge is held back so that the final one can carry
// last_result; the search stalls only when that holding register and the
// output register are both full. Requests are refused while a search runs.
//
module dfs_edge_classifier_unit #(
   parameter int MAX_NODES = 64,
   parameter int MAX_EDGES = 64
) (
   input wire logic    clock,
   input wire logic    reset,
   dfsec_req_if.sink   req_ch,
   dfsec_rsp_if.source rsp_ch,
   dfsec_csr_if.sink   csr_ch
);
   // The controller sees only status; the datapath owns all storage.
   dfsec_pkg::cmd_type cmd;
   dfsec_pkg::sts_type sts;

   dfsec_ctrl u_ctrl (
      .clock,
      .reset,
      .sts,
      .cmd
   );

   dfsec_dp #(
      .MAX_NODES(MAX_NODES),
      .MAX_EDGES(MAX_EDGES)
   ) u_dp (
      .clock,
      .reset,
      .cmd,
      .sts,
      .req_ch,
      .rsp_ch,
      .csr_ch
   );
endmodule
`default_nettype wire

// ----- dv/dfs_edge_classifier_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dfs_edge_classifier_checker: edge classification scoreboard
// Watches the request, result and node count channels, runs its own
// depth-first search on every graph that is closed, and compares each
// classified edge with the oldest expected one.
// ----------------------------------------------------------------------------
module dfs_edge_classifier_checker (
   input  wire logic clock,
   input  wire logic reset,
   dfsec_req_if.sink req_ch,
   dfsec_rsp_if.sink rsp_ch,
   dfsec_csr_if.sink csr_ch,
   output int        fail_count,
   output int        pending_edges
);

   typedef struct packed {
      logic [5:0]          from_node;
      logic [5:0]          to_node;
      dfsec_pkg::kind_type kind;
      logic                last_result;
   } class_edge_type;

   localparam int EDGE_CAP = 64;
   localparam int GR_WHITE = 0;
   localparam int GR_GRAY  = 1;
   localparam int GR_BLACK = 2;

   class_edge_type expected_edges[$];

   logic [6:0] node_limit;
   logic [5:0] e_dst [EDGE_CAP];
   logic [6:0] e_next [EDGE_CAP];
   logic [6:0] list_head [dfsec_pkg::ID_SPACE];
   logic [6:0] list_tail [dfsec_pkg::ID_SPACE];
   int         edge_total;

   assign pending_edges = expected_edges.size();

   function automatic void clear_graph();
      for (int i = 0; i < dfsec_pkg::ID_SPACE; i++) begin
         list_head[i] = dfsec_pkg::NULL_LINK;
         list_tail[i] = dfsec_pkg::NULL_LINK;
      end
      edge_total = 0;
   endfunction

   function automatic void classify_graph();
      int             color [dfsec_pkg::ID_SPACE];
      logic [7:0]     disc [dfsec_pkg::ID_SPACE];
      logic [7:0]     clock_tick;
      int             stk_node [dfsec_pkg::ID_SPACE];
      logic [6:0]     stk_cur [dfsec_pkg::ID_SPACE];
      int             depth;
      int             emitted;
      int             roots;
      int             u, w, c;
      class_edge_type ce;
      roots = (node_limit > 7'd64) ? 64 : int'(node_limit);
      for (int i = 0; i < dfsec_pkg::ID_SPACE; i++) begin
         color[i] = GR_WHITE;
         disc[i] = '0;
      end
      clock_tick = '0;
      depth = 0;
      emitted = 0;
      for (int r = 0; r < roots; r++) begin
         if (color[r] != GR_WHITE) continue;
         color[r] = GR_GRAY;
         clock_tick++;
         disc[r] = clock_tick;
         stk_node[0] = r;
         stk_cur[0] = list_head[r];
         depth = 1;
         while (depth > 0) begin
            u = stk_node[depth-1];
            c = int'(stk_cur[depth-1]);
            if (c >= EDGE_CAP || c >= edge_total) begin
               color[u] = GR_BLACK;
               clock_tick++;
               depth--;
               continue;
            end
            stk_cur[depth-1] = e_next[c];
            w = int'(e_dst[c]);
            ce.from_node = 6'(u);
            ce.to_node = 6'(w);
            ce.last_result = 1'b0;
            if (color[w] == GR_WHITE) ce.kind = dfsec_pkg::KIND_TREE;
            else if (color[w] == GR_GRAY) ce.kind = dfsec_pkg::KIND_BACK;
            else if (disc[u] < disc[w]) ce.kind = dfsec_pkg::KIND_FORWARD;
            else ce.kind = dfsec_pkg::KIND_CROSS;
            if (emitted < EDGE_CAP) begin
               expected_edges.insert(expected_edges.size(), ce);
               emitted++;
            end
            if (ce.kind == dfsec_pkg::KIND_TREE) begin
               color[w] = GR_GRAY;
               clock_tick++;
               disc[w] = clock_tick;
               if (depth < dfsec_pkg::ID_SPACE) begin
                  stk_node[depth] = w;
                  stk_cur[depth] = list_head[w];
                  depth++;
               end
            end
         end
      end
      if (emitted > 0) expected_edges[$].last_result = 1'b1;
   endfunction

   function automatic void load_edge(logic [5:0] s, logic [5:0] d);
      int lim;
      lim = (node_limit > 7'd64) ? 64 : int'(node_limit);
      if (int'(s) < lim && int'(d) < lim && edge_total < EDGE_CAP) begin
         e_dst[edge_total] = d;
         e_next[edge_total] = dfsec_pkg::NULL_LINK;
         if (list_head[s] == dfsec_pkg::NULL_LINK) list_head[s] = 7'(edge_total);
         else e_next[list_tail[s]] = 7'(edge_total);
         list_tail[s] = 7'(edge_total);
         edge_total++;
      end
   endfunction

   always @(posedge clock) begin
      class_edge_type want;
      if (reset) begin
         node_limit = 7'd64;
         clear_graph();
         expected_edges.delete();
         fail_count = 0;
      end else begin
         if (csr_ch.valid && csr_ch.ready) node_limit = csr_ch.node_count;
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (expected_edges.size() == 0) begin
               fail_count++;
               if (fail_count <= 10)
                  $display("unexpected edge %0d->%0d kind %0d", rsp_ch.from_node,
                           rsp_ch.to_node, rsp_ch.edge_kind);
            end else begin
               want = expected_edges.pop_front();
               if (want.from_node !== rsp_ch.from_node || want.to_node !== rsp_ch.to_node ||
                   want.kind !== rsp_ch.edge_kind ||
                   want.last_result !== rsp_ch.last_result) begin
                  fail_count++;
                  if (fail_count <= 10)
                     $display("mismatch: expected %0d->%0d k%0d l%0d, got %0d->%0d k%0d l%0d",
                              want.from_node, want.to_node, want.kind, want.last_result,
                              rsp_ch.from_node, rsp_ch.to_node, rsp_ch.edge_kind,
                              rsp_ch.last_result);
               end
            end
         end
         if (req_ch.valid && req_ch.ready) begin
            load_edge(req_ch.source_node, req_ch.dest_node);
            if (req_ch.last_edge) begin
               classify_graph();
               clear_graph();
            end
         end
      end
   end

endmodule

// ----- dv/dfs_edge_classifier_unit_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dfs_edge_classifier_unit_tb: depth-first search classifier testbench
// Sends graphs of directed edges with random pacing, changes the node count
// between graphs, and lets the checker compare every classified edge.
// ----------------------------------------------------------------------------
module dfs_edge_classifier_unit_tb;

   logic clock;
   logic reset;
   int   fail_count;
   int   pending_edges;
   int   sent_requests;
   bit   hold_rsp;   // set during the long receiver stall

   dfsec_req_if req_ch ();
   dfsec_rsp_if rsp_ch ();
   dfsec_csr_if csr_ch ();

   dfs_edge_classifier_unit u_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch.sink),
      .rsp_ch (rsp_ch.source),
      .csr_ch (csr_ch.sink)
   );

   dfs_edge_classifier_checker u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_ch        (req_ch.sink),
      .rsp_ch        (rsp_ch.sink),
      .csr_ch        (csr_ch.sink),
      .fail_count    (fail_count),
      .pending_edges (pending_edges)
   );

   always begin
      clock = 1'b1;
      #1;
      clock = 1'b0;
      #1;
   end

   // Most requests follow at once or after a short gap; now and then a long one.
   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 50) return 0;
      if (roll < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // Send one edge request and hold it until the block takes it. Ready is
   // sampled mid-cycle so that the accepting edge is known before it comes.
   // The request drops as it is accepted; the wait after that costs nothing,
   // since the block stores and links each request before it is ready again.
   task automatic send_edge(input logic [5:0] s, input logic [5:0] d, input logic lst,
                            input bit paced);
      int gap;
      gap = paced ? pick_gap() : 0;
      repeat (gap) @(posedge clock);
      req_ch.valid       <= 1'b1;
      req_ch.source_node <= s;
      req_ch.dest_node   <= d;
      req_ch.last_edge   <= lst;
      @(negedge clock);
      while (!req_ch.ready) @(negedge clock);
      @(posedge clock);
      req_ch.valid <= 1'b0;
      sent_requests++;
      @(posedge clock);
   endtask

   // Wait for every expected edge, then let the block settle. Dropped last
   // requests with no results still run a short search inside the block.
   task automatic drain();
      while (pending_edges != 0) @(posedge clock);
      repeat (400) @(posedge clock);
   endtask

   // The register is written only while the block is idle.
   task automatic write_node_count(input logic [6:0] n);
      drain();
      csr_ch.valid      <= 1'b1;
      csr_ch.node_count <= n;
      @(posedge clock);
      while (!csr_ch.ready) @(posedge clock);
      csr_ch.valid <= 1'b0;
   endtask

   // A random graph: nodes mostly inside the count, with a few strays that
   // test the out of range drop.
   task automatic send_graph(input int n_nodes, input int n_edges);
      int hi;
      logic [5:0] s, d;
      hi = (n_nodes > 64) ? 63 : ((n_nodes < 1) ? 0 : n_nodes - 1);
      for (int i = 0; i < n_edges; i++) begin
         s = ($urandom_range(0, 19) == 0) ? 6'($urandom) : 6'($urandom_range(0, hi));
         d = ($urandom_range(0, 19) == 0) ? 6'($urandom) : 6'($urandom_range(0, hi));
         send_edge(s, d, i == n_edges - 1, 1'b1);
      end
   endtask

   // Result side: random stalls, plus one long hold-off when asked.
   always @(posedge clock) begin
      if (reset) rsp_ch.ready <= 1'b0;
      else if (hold_rsp) rsp_ch.ready <= 1'b0;
      else rsp_ch.ready <= ($urandom_range(0, 99) < 70) || ($urandom_range(0, 3) == 0);
   end

   initial begin
      #200000;
      $display("tb: failure");
      $finish;
   end

   initial begin
      int nsel;
      req_ch.valid       <= 1'b0;
      req_ch.source_node <= '0;
      req_ch.dest_node   <= '0;
      req_ch.last_edge   <= 1'b0;
      csr_ch.valid       <= 1'b0;
      csr_ch.node_count  <= 7'd64;
      hold_rsp           = 1'b0;
      sent_requests      = 0;
      reset              <= 1'b1;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part at the reset node count of 64.
      // An empty search: the only edge is the last one but is out of range
      // for nothing, so send a self loop, which must come back as back.
      send_edge(6'd0, 6'd0, 1'b1, 1'b0);
      // Tree, back, forward and cross in one small graph.
      send_edge(6'd0, 6'd1, 1'b0, 1'b0);
      send_edge(6'd1, 6'd2, 1'b0, 1'b0);
      send_edge(6'd2, 6'd0, 1'b0, 1'b0);
      send_edge(6'd0, 6'd2, 1'b0, 1'b0);
      send_edge(6'd3, 6'd1, 1'b0, 1'b0);
      send_edge(6'd63, 6'd63, 1'b1, 1'b0);
      // Highest ids with all bits set and a chain from 62 up.
      send_edge(6'd62, 6'd63, 1'b0, 1'b0);
      send_edge(6'd63, 6'd0, 1'b1, 1'b0);
      drain();

      // Small count: out of range edges are dropped, and a last request
      // that is dropped still starts the search on what was loaded.
      write_node_count(7'd4);
      send_edge(6'd1, 6'd3, 1'b0, 1'b0);
      send_edge(6'd3, 6'd1, 1'b0, 1'b0);
      send_edge(6'd5, 6'd1, 1'b0, 1'b0);
      send_edge(6'd2, 6'd40, 1'b1, 1'b0);
      // Empty search: nothing valid at all.
      send_edge(6'd9, 6'd9, 1'b1, 1'b0);
      // Zero count: every edge is dropped.
      write_node_count(7'd0);
      send_edge(6'd0, 6'd0, 1'b0, 1'b0);
      send_edge(6'd0, 6'd0, 1'b1, 1'b0);
      // Count above the id space is clamped.
      write_node_count(7'd127);
      send_edge(6'd10, 6'd20, 1'b1, 1'b0);
      // Shrunken count: edges loaded at 64, walked after a drop to 1 needs
      // the write mid-graph, which is not allowed, so use count 1 fully.
      write_node_count(7'd1);
      send_edge(6'd0, 6'd0, 1'b0, 1'b0);
      send_edge(6'd0, 6'd0, 1'b1, 1'b0);

      // Full store with the receiver held off, so the block fills and
      // refuses requests while it waits.
      write_node_count(7'd64);
      hold_rsp = 1'b1;
      fork
         begin
            repeat (300) @(posedge clock);
            hold_rsp = 1'b0;
         end
         begin
            for (int i = 0; i < 70; i++)
               send_edge(6'($urandom_range(0, 7)), 6'($urandom_range(0, 7)),
                         i == 69, 1'b0);
            send_graph(8, 6);
         end
      join
      drain();

      // Random graphs across several node counts.
      while (sent_requests < 330) begin
         nsel = $urandom_range(0, 9);
         if (nsel < 6) write_node_count(7'($urandom_range(2, 12)));
         else if (nsel < 8) write_node_count(7'($urandom_range(13, 64)));
         else if (nsel == 8) write_node_count(7'd64);
         else write_node_count(7'($urandom_range(65, 127)));
         repeat ($urandom_range(1, 3)) send_graph($urandom_range(2, 16), $urandom_range(1, 24));
      end

      drain();
      if (fail_count == 0) $display("tb: success");
      else $display("tb: failure");
      $finish;
   end

endmodule
